### design/srh_pkg.sv
// Package for the sequence reorder / hold-back engine.
// Item structs, result kind and message mode codes, store sizing constants.
// No dependencies.
package srh_pkg;

    // Hold-back store depth; a power of two so the slot is the low sequence bits
    localparam int WINDOW       = 16;
    localparam int SLOT_W       = $clog2(WINDOW);
    localparam int PAYLOAD_BITS = 32;
    localparam int MAX_RESULTS  = 16;
    localparam int CNT_W        = $clog2(MAX_RESULTS + 1);
    localparam int GAP_MIN      = 2;

    localparam logic [31:0] PAY_MASK =
        (PAYLOAD_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << PAYLOAD_BITS) - 64'd1);

    localparam logic [1:0] MODE_DATA     = 2'd0;
    localparam logic [1:0] MODE_NOTFOUND = 2'd1;

    localparam logic [1:0] KIND_DELIVER    = 2'd0;
    localparam logic [1:0] KIND_RETRANSMIT = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW   = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] seq_num;
        logic [31:0] payload;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] out_seq;
        logic [31:0] out_payload;
        logic        last;
    } t_out_item;

endpackage

### design/sequence_reorder_holdback_top.sv
// Busy covers the store walk for each item; the final result is strobed, marked last, in the
// same cycle that busy drops, so a new item can be accepted while that result is on the port.
// At most one result per cycle, as the sequencer walks the store one slot per cycle.
// Receiver cannot stall; results are strobed for one cycle each, last one marked.
// Synchronous active-low reset: expected sequence 0, store valid bits cleared.
module sequence_reorder_holdback_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  srh_pkg::t_in_item   i_item,
    output logic                o_strobe,
    output srh_pkg::t_out_item  o_result,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [31:0]         i_cfg_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DRAIN = 2'd1;
    localparam logic [1:0] ST_GAP   = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]                   r_state, n_state;
    logic [31:0]                  r_exp, n_exp;
    logic [srh_pkg::WINDOW-1:0]   r_held_valid, n_held_valid;
    logic [31:0]                  r_held_payload [srh_pkg::WINDOW];
    logic [srh_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [srh_pkg::SLOT_W-1:0]   r_idx, n_idx;
    logic [srh_pkg::SLOT_W-1:0]   r_dist, n_dist;
    logic                         r_pend_valid, n_pend_valid;
    srh_pkg::t_out_item           r_pend, n_pend;
    logic                         r_strobe, n_strobe;
    srh_pkg::t_out_item           r_out, n_out;

    logic                         accept;
    logic                         cfg_wr;
    logic [31:0]                  seq_delta;
    logic [31:0]                  gap_seq;
    logic [srh_pkg::SLOT_W-1:0]   gap_slot;
    logic [srh_pkg::SLOT_W-1:0]   exp_slot;
    logic                         cnt_full;
    logic                         prod_valid;
    srh_pkg::t_out_item           prod_item;
    logic                         flush;
    logic                         wr_en;
    logic [srh_pkg::SLOT_W-1:0]   wr_idx;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign accept      = start && !busy;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign o_strobe    = r_strobe;
    assign o_result    = r_out;

    // arithmetic: distance on accept, expected + offset during the gap walk
    assign seq_delta = i_item.seq_num - r_exp;
    assign gap_seq   = r_exp + 32'(r_idx);
    assign gap_slot  = r_exp[srh_pkg::SLOT_W-1:0] + r_idx;
    assign exp_slot  = r_exp[srh_pkg::SLOT_W-1:0];
    assign cnt_full  = (r_cnt >= srh_pkg::CNT_W'(srh_pkg::MAX_RESULTS));

    always_comb begin
        n_state      = r_state;
        n_exp        = r_exp;
        n_held_valid = r_held_valid;
        n_cnt        = r_cnt;
        n_idx        = r_idx;
        n_dist       = r_dist;
        prod_valid   = 1'b0;
        prod_item    = '0;
        flush        = 1'b0;
        wr_en        = 1'b0;
        wr_idx       = i_item.seq_num[srh_pkg::SLOT_W-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_FLUSH;
                    n_cnt   = '0;
                    if (i_item.mode == srh_pkg::MODE_NOTFOUND) begin
                        n_held_valid[exp_slot] = 1'b0;
                        n_exp   = r_exp + 32'd1;
                        n_state = ST_DRAIN;
                    end else if (i_item.mode == srh_pkg::MODE_DATA) begin
                        if (seq_delta == 32'd0) begin
                            prod_valid            = 1'b1;
                            prod_item.kind        = srh_pkg::KIND_DELIVER;
                            prod_item.out_seq     = i_item.seq_num;
                            prod_item.out_payload = i_item.payload & srh_pkg::PAY_MASK;
                            n_held_valid[exp_slot] = 1'b0;
                            n_exp   = r_exp + 32'd1;
                            n_cnt   = srh_pkg::CNT_W'(1);
                            n_state = ST_DRAIN;
                        end else if (seq_delta < 32'(srh_pkg::WINDOW)) begin
                            // duplicate keeps the first copy
                            if (!r_held_valid[wr_idx]) begin
                                n_held_valid[wr_idx] = 1'b1;
                                wr_en = 1'b1;
                            end
                            if (seq_delta >= 32'(srh_pkg::GAP_MIN)) begin
                                n_idx   = '0;
                                n_dist  = seq_delta[srh_pkg::SLOT_W-1:0];
                                n_state = ST_GAP;
                            end
                        end else if (!seq_delta[31]) begin
                            prod_valid        = 1'b1;
                            prod_item.kind    = srh_pkg::KIND_OVERFLOW;
                            prod_item.out_seq = i_item.seq_num;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (!cnt_full && r_held_valid[exp_slot]) begin
                    prod_valid            = 1'b1;
                    prod_item.kind        = srh_pkg::KIND_DELIVER;
                    prod_item.out_seq     = r_exp;
                    prod_item.out_payload = r_held_payload[exp_slot];
                    n_held_valid[exp_slot] = 1'b0;
                    n_exp = r_exp + 32'd1;
                    n_cnt = r_cnt + srh_pkg::CNT_W'(1);
                end else begin
                    n_state = ST_FLUSH;
                end
            end
            ST_GAP: begin
                if (!cnt_full && (r_idx < r_dist)) begin
                    if (!r_held_valid[gap_slot]) begin
                        prod_valid        = 1'b1;
                        prod_item.kind    = srh_pkg::KIND_RETRANSMIT;
                        prod_item.out_seq = gap_seq;
                        n_cnt = r_cnt + srh_pkg::CNT_W'(1);
                    end
                    n_idx = r_idx + srh_pkg::SLOT_W'(1);
                end else begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                flush   = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase

        if (cfg_wr) begin
            n_exp        = i_cfg_data;
            n_held_valid = '0;
        end
    end

    // one-deep pending stage: a result goes out once the next one (or the end) is known
    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_strobe     = 1'b0;
        n_out        = r_out;
        if (prod_valid) begin
            if (r_pend_valid) begin
                n_strobe   = 1'b1;
                n_out      = r_pend;
                n_out.last = 1'b0;
            end
            n_pend       = prod_item;
            n_pend_valid = 1'b1;
        end else if (flush && r_pend_valid) begin
            n_strobe     = 1'b1;
            n_out        = r_pend;
            n_out.last   = 1'b1;
            n_pend_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_exp        <= '0;
            r_held_valid <= '0;
            r_cnt        <= '0;
            r_idx        <= '0;
            r_dist       <= '0;
            r_pend_valid <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_exp        <= n_exp;
            r_held_valid <= n_held_valid;
            r_cnt        <= n_cnt;
            r_idx        <= n_idx;
            r_dist       <= n_dist;
            r_pend_valid <= n_pend_valid;
            r_strobe     <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
        if (wr_en) begin
            r_held_payload[wr_idx] <= i_item.payload & srh_pkg::PAY_MASK;
        end
    end

endmodule

### design/srh_checker.sv
// Port-level checker for the sequence reorder / hold-back engine, with its bind.
// Depends on srh_pkg and sequence_reorder_holdback_top.
module srh_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               o_strobe,
    input  srh_pkg::t_out_item o_result,
    input  logic               o_cfg_ready
);

    // an accepted item always raises busy in the cycle after it is taken
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !busy)
        else $error("config ready while busy");

    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.kind != srh_pkg::KIND_DELIVER) |-> (o_result.out_payload == 32'd0))
        else $error("non-deliver result carries payload");

    // once the engine is idle, the result on the port must be the final one
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !busy) |-> o_result.last)
        else $error("non-final result with engine idle");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |=> !o_strobe)
        else $error("result directly after final beat");

endmodule

bind sequence_reorder_holdback_top srh_checker u_srh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_result    (o_result),
    .o_cfg_ready (o_cfg_ready)
);
